// File: rtl/ln_pkg.sv
// Shared types and constants for the layer normalization block.
// Used by the controller, the datapath, the top level, the checker and the testbench.
package ln_pkg;

    // Field widths of the transaction payloads.
    localparam int CNT_W   = 7;   // feature count and fill count
    localparam int IDX_W   = 6;   // feature index on the ports
    localparam int DATA_W  = 16;  // sample, gain, offset and result

    // Datapath widths, sized for 16-bit samples and rows of up to 64 features.
    localparam int SUM_W   = 22;  // signed row sum
    localparam int D_W     = 24;  // signed n*x - sum
    localparam int SQ_W    = 48;  // square of one deviation
    localparam int ACC_W   = 52;  // sum of squared deviations
    localparam int N2_W    = 14;
    localparam int N3_W    = 21;
    localparam int V_W     = 34;  // variance plus eps, unsigned Q34.0
    localparam int RAD_W   = 50;  // radicand of the square root
    localparam int ROOT_W  = 25;  // root, unsigned Q17.8
    localparam int DEN_W   = 32;  // n times root
    localparam int PROD_W  = 40;  // deviation times gain
    localparam int DIVN_W  = 52;  // dividend of the shared divider
    localparam int RES_W   = 56;  // term plus offset before saturation

    // Input opcodes.
    localparam logic OPC_PARAM  = 1'b0;
    localparam logic OPC_SAMPLE = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_EPS_VALUE     = 1'b1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_SUM,
        OP_DEV,
        OP_SQ,
        OP_ACC,
        OP_N2,
        OP_N3,
        OP_VDIV,
        OP_VEPS,
        OP_SQRT,
        OP_DEN,
        OP_NUM,
        OP_TDIV,
        OP_OUT
    } t_op;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_SQ_RD,
        S_SQ_DEV,
        S_SQ_MUL,
        S_SQ_ACC,
        S_N2,
        S_N3,
        S_VDIV,
        S_VDIV_W,
        S_VEPS,
        S_SQRT,
        S_SQRT_W,
        S_DEN,
        S_T_RD,
        S_T_DEV,
        S_T_NUM,
        S_T_DIV,
        S_T_DIV_W,
        S_T_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] addr;
        logic [CNT_W-1:0] n;
        logic             last;
        logic             wr_sample;
        logic             wr_param;
        logic [IDX_W-1:0] wr_addr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic sqrt_done;
        logic den_zero;
        logic out_free;
        logic out_valid;
    } t_status;

endpackage

// File: rtl/layer_normalization.sv
// Layer normalization, fixed point. Top level: configuration registers on an
// APB-style port, the controller and the datapath. Depends on ln_pkg.
//
// Input channel (i_in_valid / o_in_stall): opcode 0 writes a gain/offset pair
// at i_feature_index, opcode 1 appends i_sample to the current row. A
// transaction is taken only while the block is idle. The transaction
// that completes a row of feature_count samples starts the row processing and
// the input stays stalled until the last result of the row has been handed to
// the output register.
// Row processing: a sum pass over the row, a variance pass of read, deviation,
// square and accumulate per feature, n squared and cubed, the variance divide
// and the square root, then one result per feature, divided, unless the root
// is zero, by the one-bit-per-cycle divider that also did the variance divide.
// Output channel (o_out_valid / i_out_stall): one result per feature in order,
// last_of_row on the final one. A stalled result holds; the next one waits in
// the datapath until the output register is free.
// Reset clears the fill count, the controller and the output valid, and loads
// feature_count = 64 and eps_value = 1. The stores keep their contents.
module layer_normalization #(
    parameter int MAX_FEATURES = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // Input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic [ln_pkg::IDX_W-1:0]         i_feature_index,
    input  logic signed [ln_pkg::DATA_W-1:0] i_gain_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_offset_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_sample,
    // Output channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [ln_pkg::DATA_W-1:0] o_result_value,
    output logic [ln_pkg::IDX_W-1:0]         o_feature_position,
    output logic                             o_last_of_row
);
    import ln_pkg::*;

    logic [CNT_W-1:0] r_feature_count;
    logic [15:0]      r_eps_value;
    logic             cfg_wr;
    t_cmd             cmd;
    t_status          status;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= CNT_W'(64);
            r_eps_value     <= 16'd1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FEATURE_COUNT: r_feature_count <= pwdata[CNT_W-1:0];
                REG_EPS_VALUE:     r_eps_value     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            REG_FEATURE_COUNT: prdata = 32'(r_feature_count);
            REG_EPS_VALUE:     prdata = 32'(r_eps_value);
            default:           prdata = '0;
        endcase
    end

    ln_ctrl #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_feature_count (r_feature_count),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_feature_index (i_feature_index),
        .o_cmd           (cmd),
        .i_status        (status)
    );

    ln_datapath #(
        .MAX_FEATURES(MAX_FEATURES),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_eps_value        (r_eps_value),
        .i_gain_value       (i_gain_value),
        .i_offset_value     (i_offset_value),
        .i_sample           (i_sample),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_result_value     (o_result_value),
        .o_feature_position (o_feature_position),
        .o_last_of_row      (o_last_of_row)
    );

endmodule

// File: rtl/ln_div.sv
// Restoring divider, one quotient bit per cycle.
// Stand-alone arithmetic unit; no package dependencies.
module ln_div #(
    parameter int NW = 52,
    parameter int VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff[VW-1:0] : shifted[VW-1:0];
        n_quo   = {r_quo[NW-2:0], ge};
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CW'(NW);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operands and partial results.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/ln_sqrt.sv
// Integer square root, digit by digit, one root bit per cycle.
// Stand-alone arithmetic unit; no package dependencies.
module ln_sqrt #(
    parameter int RW = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RW-1:0]    i_radicand,
    output logic             o_done,
    output logic [RW/2-1:0]  o_root
);
    localparam int OW = RW / 2;
    localparam int CW = $clog2(OW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_rad;
    logic [OW+1:0] r_rem, n_rem;
    logic [OW-1:0] r_root, n_root;
    logic [OW+1:0] shifted;
    logic [OW+1:0] trial;
    logic          ge;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        shifted = {r_rem[OW-1:0], r_rad[RW-1:RW-2]};
        trial   = {r_root, 2'b01};
        ge      = (shifted >= trial);
        n_rem   = ge ? (shifted - trial) : shifted;
        n_root  = {r_root[OW-2:0], ge};
        n_busy  = r_busy;
        n_done  = r_done;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CW'(OW);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Radicand shifter, remainder and root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/ln_datapath.sv
// Datapath: per-feature stores, row statistics, shared divider and square root,
// and the output register. Depends on ln_pkg, ln_div and ln_sqrt.
module ln_datapath #(
    parameter int MAX_FEATURES = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ln_pkg::t_cmd                    i_cmd,
    output ln_pkg::t_status                 o_status,
    input  logic [15:0]                     i_eps_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_gain_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_offset_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_sample,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic signed [ln_pkg::DATA_W-1:0] o_result_value,
    output logic [ln_pkg::IDX_W-1:0]        o_feature_position,
    output logic                            o_last_of_row
);
    import ln_pkg::*;

    localparam int AW  = $clog2(MAX_FEATURES);
    localparam int SWE = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
    localparam logic signed [RES_W-1:0] MAXV =
        (RES_W'(1) <<< (SAMPLE_WIDTH - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] MINV = -MAXV - RES_W'(1);

    // Per-feature stores.
    logic [SWE-1:0]    sample_mem [MAX_FEATURES];
    logic [DATA_W-1:0] gain_mem   [MAX_FEATURES];
    logic [DATA_W-1:0] offset_mem [MAX_FEATURES];

    logic [SWE-1:0]           r_rd_x;
    logic signed [DATA_W-1:0] r_rd_g;
    logic signed [DATA_W-1:0] r_rd_o;

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [D_W-1:0]    r_dev;
    logic [SQ_W-1:0]          r_sq;
    logic [ACC_W-1:0]         r_sumsq;
    logic [N2_W-1:0]          r_n2;
    logic [N3_W-1:0]          r_n3;
    logic [V_W-1:0]           r_v;
    logic [DEN_W-1:0]         r_den;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_res;
    logic [IDX_W-1:0]         r_pos;
    logic                     r_last;

    logic signed [DATA_W-1:0] x16;
    logic signed [CNT_W:0]    n_s;
    logic signed [D_W-1:0]    nx;
    logic signed [D_W-1:0]    dev;
    logic signed [SQ_W-1:0]   dd;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        mag;
    logic                     div_start;
    logic [DIVN_W-1:0]        div_num;
    logic [DEN_W-1:0]         div_dvs;
    logic                     div_busy;
    logic                     div_done;
    logic [DIVN_W-1:0]        div_quo;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        root;
    logic                     den_zero;
    logic                     out_free;
    logic [DIVN_W-1:0]        q;
    logic signed [RES_W-1:0]  term;
    logic signed [RES_W-1:0]  res_full;
    logic signed [RES_W-1:0]  res_sat;

    // Store writes from input transactions.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample) begin
            sample_mem[i_cmd.wr_addr[AW-1:0]] <= i_sample[SWE-1:0];
        end
        if (i_cmd.wr_param) begin
            gain_mem[i_cmd.wr_addr[AW-1:0]]   <= i_gain_value;
            offset_mem[i_cmd.wr_addr[AW-1:0]] <= i_offset_value;
        end
    end

    // Registered reads at the controller's feature address.
    always_ff @(posedge i_clk) begin
        r_rd_x <= sample_mem[i_cmd.addr[AW-1:0]];
        r_rd_g <= gain_mem[i_cmd.addr[AW-1:0]];
        r_rd_o <= offset_mem[i_cmd.addr[AW-1:0]];
    end

    // Deviation and product arithmetic.
    always_comb begin
        x16  = DATA_W'($signed(r_rd_x));
        n_s  = $signed({1'b0, i_cmd.n});
        nx   = n_s * x16;
        dev  = nx - D_W'(r_sum);
        dd   = r_dev * r_dev;
        prod = r_dev * r_rd_g;
        mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    end

    // Shared divider: variance first, then one rounded quotient per feature unless the root is zero.
    assign div_start = (i_cmd.op == OP_VDIV) || (i_cmd.op == OP_TDIV);
    always_comb begin
        if (i_cmd.op == OP_VDIV) begin
            div_num = r_sumsq;
            div_dvs = DEN_W'(r_n3);
        end else begin
            div_num = DIVN_W'({mag, 6'b0}) + DIVN_W'(r_den >> 1);
            div_dvs = r_den;
        end
    end

    ln_div #(
        .NW(DIVN_W),
        .VW(DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign sqrt_start = (i_cmd.op == OP_SQRT);

    ln_sqrt #(
        .RW(RAD_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({r_v, 16'b0}),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // Statistics registers, updated by the operation in flight.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CLR: begin
                r_sum   <= '0;
                r_sumsq <= '0;
            end
            OP_SUM:  r_sum   <= r_sum + SUM_W'(x16);
            OP_DEV:  r_dev   <= dev;
            OP_SQ:   r_sq    <= SQ_W'(dd);
            OP_ACC:  r_sumsq <= r_sumsq + ACC_W'(r_sq);
            OP_N2:   r_n2    <= N2_W'(i_cmd.n) * N2_W'(i_cmd.n);
            OP_N3:   r_n3    <= N3_W'(r_n2) * N3_W'(i_cmd.n);
            OP_VEPS: r_v     <= V_W'(div_quo) + V_W'(i_eps_value);
            OP_DEN:  r_den   <= DEN_W'(root) * DEN_W'(i_cmd.n);
            OP_NUM:  r_prod  <= prod;
            default: begin
            end
        endcase
    end

    // Sign, offset and saturation of one result.
    assign den_zero = (r_den == '0);
    always_comb begin
        q        = den_zero ? '0 : div_quo;
        term     = r_prod[PROD_W-1] ? -RES_W'(q) : RES_W'(q);
        res_full = term + RES_W'(r_rd_o);
        priority if (res_full > MAXV) begin
            res_sat = MAXV;
        end else if (res_full < MINV) begin
            res_sat = MINV;
        end else begin
            res_sat = res_full;
        end
    end

    // Output register; a new result loads when the slot is empty or being taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT && out_free) begin
            r_res  <= res_sat[DATA_W-1:0];
            r_pos  <= i_cmd.addr;
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_value     = r_res;
    assign o_feature_position = r_pos;
    assign o_last_of_row      = r_last;

    always_comb begin
        o_status.div_busy  = div_busy;
        o_status.div_done  = div_done;
        o_status.sqrt_done = sqrt_done;
        o_status.den_zero  = den_zero;
        o_status.out_free  = out_free;
        o_status.out_valid = r_out_valid;
    end

endmodule

// File: rtl/ln_ctrl.sv
// Controller: input acceptance, row fill count and the sequence of passes over
// a full row. Depends on ln_pkg; drives ln_datapath through t_cmd.
module ln_ctrl #(
    parameter int MAX_FEATURES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ln_pkg::CNT_W-1:0] i_feature_count,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [ln_pkg::IDX_W-1:0] i_feature_index,
    output ln_pkg::t_cmd             o_cmd,
    input  ln_pkg::t_status          i_status
);
    import ln_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] fill_base;
    logic [CNT_W-1:0] fill_inc;
    logic             accept;
    logic             j_last;

    // Effective feature count: zero acts as one, large values clamp.
    always_comb begin
        priority if (i_feature_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (i_feature_count > CNT_W'(MAX_FEATURES)) begin
            n_eff = CNT_W'(MAX_FEATURES);
        end else begin
            n_eff = i_feature_count;
        end
    end

    // A partial row left over from a larger count is dropped once it holds at least the new count.
    assign fill_base = (r_fill >= n_eff) ? '0 : r_fill;
    assign fill_inc  = fill_base + 1'b1;
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign j_last    = (r_j == r_n - 1'b1);

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_fill          = r_fill;
        n_j             = r_j;
        o_cmd.op        = OP_NONE;
        o_cmd.addr      = r_j[IDX_W-1:0];
        o_cmd.n         = r_n;
        o_cmd.last      = j_last;
        o_cmd.wr_sample = 1'b0;
        o_cmd.wr_param  = 1'b0;
        o_cmd.wr_addr   = i_feature_index;
        o_in_stall      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_CLR;
                if (accept && i_opcode == OPC_PARAM) begin
                    o_cmd.wr_param = ({1'b0, i_feature_index} < CNT_W'(MAX_FEATURES));
                end else if (accept) begin
                    o_cmd.wr_sample = 1'b1;
                    o_cmd.wr_addr   = fill_base[IDX_W-1:0];
                    if (fill_inc == n_eff) begin
                        n_fill  = '0;
                        n_j     = '0;
                        n_state = S_SUM_RD;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
            end
            S_SUM_RD: n_state = S_SUM_ACC;
            S_SUM_ACC: begin
                o_cmd.op = OP_SUM;
                if (j_last) begin
                    n_j     = '0;
                    n_state = S_SQ_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_SQ_RD: n_state = S_SQ_DEV;
            S_SQ_DEV: begin
                o_cmd.op = OP_DEV;
                n_state  = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_cmd.op = OP_SQ;
                n_state  = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.op = OP_ACC;
                if (j_last) begin
                    n_j     = '0;
                    n_state = S_N2;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SQ_RD;
                end
            end
            S_N2: begin
                o_cmd.op = OP_N2;
                n_state  = S_N3;
            end
            S_N3: begin
                o_cmd.op = OP_N3;
                n_state  = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.op = OP_VDIV;
                n_state  = S_VDIV_W;
            end
            S_VDIV_W: begin
                if (i_status.div_done) begin
                    n_state = S_VEPS;
                end
            end
            S_VEPS: begin
                o_cmd.op = OP_VEPS;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_SQRT_W;
            end
            S_SQRT_W: begin
                if (i_status.sqrt_done) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.op = OP_DEN;
                n_j      = '0;
                n_state  = S_T_RD;
            end
            S_T_RD: n_state = S_T_DEV;
            S_T_DEV: begin
                o_cmd.op = OP_DEV;
                n_state  = S_T_NUM;
            end
            S_T_NUM: begin
                o_cmd.op = OP_NUM;
                n_state  = S_T_DIV;
            end
            S_T_DIV: begin
                // A zero root skips the divide; the result is the offset alone.
                if (i_status.den_zero) begin
                    n_state = S_T_OUT;
                end else begin
                    o_cmd.op = OP_TDIV;
                    n_state  = S_T_DIV_W;
                end
            end
            S_T_DIV_W: begin
                if (i_status.div_done) begin
                    n_state = S_T_OUT;
                end
            end
            S_T_OUT: begin
                o_cmd.op = OP_OUT;
                if (i_status.out_free) begin
                    if (j_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_T_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, fill count and feature counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_j     <= '0;
            r_n     <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_j     <= n_j;
            if (r_state == S_IDLE) begin
                r_n <= n_eff;
            end
        end
    end

    // The feature counter stays inside the row while a row is processed.
    a_j_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_j < r_n))
        else $error("feature counter left the row");

    // The shared divider is never restarted while it is still working.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VDIV || (r_state == S_T_DIV && !i_status.den_zero))
        |-> !i_status.div_busy)
        else $error("divider started while busy");

    // A sample that fills the row starts the statistics pass.
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OPC_SAMPLE && fill_inc == n_eff)
        |=> (r_state == S_SUM_RD))
        else $error("full row did not start processing");

    // A result handed to a free output slot shows up as a valid transaction.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T_OUT && i_status.out_free) |=> i_status.out_valid)
        else $error("result lost at the output register");

endmodule

// File: verif/layer_normalization_checker.sv
// Checker for the layer normalization block: snoops register writes and both channels,
// predicts every normalized result and compares it field by field. Depends on ln_pkg.
`timescale 1ns / 100ps

module layer_normalization_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [ln_pkg::IDX_W-1:0]         i_feature_index,
    input  logic signed [ln_pkg::DATA_W-1:0] i_gain_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_offset_value,
    input  logic signed [ln_pkg::DATA_W-1:0] i_sample,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic signed [ln_pkg::DATA_W-1:0] o_result_value,
    input  logic [ln_pkg::IDX_W-1:0]         o_feature_position,
    input  logic        o_last_of_row,
    output int          o_errors,
    output int          o_pending,
    output int          o_rows,
    output int          o_results
);
    import ln_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         position;
        logic                     last;
    } t_norm_result;

    t_norm_result norm_queue[$];

    // Shadow of the block state.
    logic signed [DATA_W-1:0] row_samples[64];
    logic signed [DATA_W-1:0] gain_shadow[64];
    logic signed [DATA_W-1:0] offset_shadow[64];
    logic [CNT_W-1:0]         count_reg;
    logic [DATA_W-1:0]        eps_reg;
    int                       fill;

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_rows = 0;
        o_results = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int active_count();
        if (count_reg == 0) return 1;
        if (count_reg > 64) return 64;
        return int'(count_reg);
    endfunction

    // Mean, variance and one scaled result per feature of the completed row.
    task automatic normalize_row(input int n);
        longint          sum;
        longint          dev;
        longint unsigned sumsq;
        longint unsigned var_q;
        longint unsigned root;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned quo;
        longint          num;
        longint          term;
        longint          r;
        t_norm_result    item;
        sum = 0;
        sumsq = 0;
        for (int j = 0; j < n; j++) sum += row_samples[j];
        for (int j = 0; j < n; j++) begin
            dev = n * longint'(row_samples[j]) - sum;
            mag = (dev < 0) ? -dev : dev;
            sumsq += mag * mag;
        end
        var_q = sumsq / (longint'(n) * n * n);
        root = int_sqrt((var_q + eps_reg) << 16);
        den = n * root;
        for (int j = 0; j < n; j++) begin
            dev = n * longint'(row_samples[j]) - sum;
            term = 0;
            if (den != 0) begin
                num = dev * longint'(gain_shadow[j]) * 64;
                mag = (num < 0) ? -num : num;
                quo = (mag + den / 2) / den;
                term = (num < 0) ? -longint'(quo) : longint'(quo);
            end
            r = term + offset_shadow[j];
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            item.value = r[DATA_W-1:0];
            item.position = j[IDX_W-1:0];
            item.last = (j == n - 1);
            norm_queue.push_back(item);
        end
        o_rows++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg <= 7'd64;
            eps_reg <= 16'd1;
            fill = 0;
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_EPS_VALUE) eps_reg <= pwdata[15:0];
                else count_reg <= pwdata[6:0];
            end
            // Input transactions.
            if (i_in_valid && !o_in_stall) begin
                if (i_opcode == OPC_PARAM) begin
                    gain_shadow[i_feature_index] = i_gain_value;
                    offset_shadow[i_feature_index] = i_offset_value;
                end else begin
                    if (fill >= active_count()) fill = 0;
                    row_samples[fill] = i_sample;
                    fill++;
                    if (fill == active_count()) begin
                        fill = 0;
                        normalize_row(active_count());
                    end
                end
            end
            // Output transactions.
            if (o_out_valid && !i_out_stall) begin
                o_results++;
                if (norm_queue.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    t_norm_result exp_item;
                    exp_item = norm_queue.pop_front();
                    if (o_result_value !== exp_item.value)
                        report_mismatch($sformatf("pos %0d value %0d, want %0d",
                            exp_item.position, o_result_value, exp_item.value));
                    if (o_feature_position !== exp_item.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                            o_feature_position, exp_item.position));
                    if (o_last_of_row !== exp_item.last)
                        report_mismatch($sformatf("pos %0d last %b, want %b",
                            exp_item.position, o_last_of_row, exp_item.last));
                end
            end
        end
        o_pending = norm_queue.size();
    end

endmodule

// File: verif/layer_normalization_tb.sv
// Testbench top for layer_normalization: drives registers, parameter and sample
// transactions and output stalls; layer_normalization_checker does the comparing.
`timescale 1ns / 100ps

module layer_normalization_tb;
    import ln_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [IDX_W-1:0]         i_feature_index;
    logic signed [DATA_W-1:0] i_gain_value;
    logic signed [DATA_W-1:0] i_offset_value;
    logic signed [DATA_W-1:0] i_sample;
    logic        o_out_valid;
    logic        i_out_stall;
    logic signed [DATA_W-1:0] o_result_value;
    logic [IDX_W-1:0]         o_feature_position;
    logic        o_last_of_row;

    int errors, pending, rows, results;
    bit calm_send, calm_recv;
    bit hold_request;
    int hold_left;

    layer_normalization i_dut (.*);

    layer_normalization_checker i_checker (
        .*, .o_errors(errors), .o_pending(pending), .o_rows(rows), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
    initial begin
        i_out_stall <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm_recv && ($urandom_range(99) < 33);
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one transaction; valid stays high afterwards for a following one.
    task automatic offer(input logic op, input logic [IDX_W-1:0] idx,
                         input logic [15:0] gain, input logic [15:0] offs,
                         input logic [15:0] smp);
        if (!calm_send && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_feature_index <= idx;
        i_gain_value <= gain;
        i_offset_value <= offs;
        i_sample <= smp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_sample(input logic [15:0] smp);
        offer(OPC_SAMPLE, IDX_W'($urandom), 16'($urandom), 16'($urandom), smp);
    endtask

    task automatic send_param(input logic [IDX_W-1:0] idx, input logic [15:0] gain,
                              input logic [15:0] offs);
        offer(OPC_PARAM, idx, gain, offs, 16'($urandom));
    endtask

    // Waits until every expected result has come and the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        unique case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(255) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int phase_count[7] = '{30, 40, 50, 50, 25, 25, 15};
        int phase_fc[7]    = '{3, 8, 127, 64, 2, 16, 1};
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= 0;
        pwdata <= 0;
        i_in_valid <= 0;
        i_opcode <= 0;
        i_feature_index <= 0;
        i_gain_value <= 0;
        i_offset_value <= 0;
        i_sample <= 0;
        calm_send = 0;
        calm_recv = 0;
        hold_request = 0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every gain and offset so no row ever reads an unwritten entry.
        for (int k = 0; k < 64; k++) send_param(IDX_W'(k), 16'($urandom), 16'($urandom));
        send_param(0, 16'h7FFF, 16'h7FFF);
        send_param(1, 16'h8000, 16'h8000);
        send_param(2, 16'h8000, 16'h7FFF);
        send_param(3, 16'h7FFF, 16'h0000);
        settle();

        // Zero root: equal samples with no eps, then saturating extremes.
        reg_write(REG_FEATURE_COUNT, 4);
        reg_write(REG_EPS_VALUE, 0);
        repeat (4) send_sample(16'h1234);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        settle();
        // A count of zero acts as one; with no eps the root is zero.
        reg_write(REG_FEATURE_COUNT, 0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        settle();
        reg_write(REG_FEATURE_COUNT, 1);
        reg_write(REG_EPS_VALUE, 65535);
        send_sample(16'h0001);
        settle();
        // Row shrunk mid-fill: three of five, then the count drops to two.
        reg_write(REG_FEATURE_COUNT, 5);
        repeat (3) send_sample(pick_sample());
        send_param(4, 16'($urandom), 16'($urandom));
        settle();
        reg_write(REG_FEATURE_COUNT, 2);
        send_sample(pick_sample());
        send_sample(pick_sample());
        settle();

        // Random phases over several register settings.
        for (int p = 0; p < 7; p++) begin
            reg_write(REG_FEATURE_COUNT, phase_fc[p]);
            reg_write(REG_EPS_VALUE, (p == 1) ? 0 : (p == 2) ? 65535 : $urandom_range(65535));
            calm_send = (p == 5);
            calm_recv = (p == 5);
            if (p == 1) hold_request = 1;
            for (int k = 0; k < phase_count[p]; k++) begin
                if ($urandom_range(99) < 15) begin
                    send_param(IDX_W'($urandom), 16'($urandom), 16'($urandom));
                end else begin
                    send_sample(pick_sample());
                end
            end
            settle();
        end

        $display("Covered %0d rows and %0d results over feature counts 0 to 127,", rows, results);
        $display("eps extremes, zero roots, saturation, shrunk rows and output back-pressure.");
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ln_pkg.sv
rtl/ln_div.sv
rtl/ln_sqrt.sv
rtl/ln_datapath.sv
rtl/ln_ctrl.sv
rtl/layer_normalization.sv
verif/layer_normalization_checker.sv
verif/layer_normalization_tb.sv
